@@ rtl/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants for the permutation cycle decomposer.
// ----------------------------------------------------------------------------
package pce_pkg;

   localparam int PCE_MAX_ELEMENTS = 32;
   localparam int PCE_VALUE_W      = 5;

   typedef struct packed {
      logic [PCE_VALUE_W-1:0] image_value;
      logic                   load_last;
   } req_type;

   typedef struct packed {
      logic [PCE_VALUE_W-1:0] member_index;
      logic                   cycle_end;
      logic                   run_end;
      logic                   no_cycles;
      logic                   bad_input;
   } rsp_type;

   // loader -> walker
   typedef struct packed {
      logic last_accepted;
      logic bad;
   } run_ctrl_type;

   // walker -> loader
   typedef struct packed {
      logic load_open;
      logic clear_run;
   } walk_status_type;

endpackage

@@ rtl/permutation_cycle_decompose.sv @@
// ----------------------------------------------------------------------------
// permutation_cycle_decompose
// Loads a permutation, validates it and emits its nontrivial cycles.
//
//   channel  dir  signals                       meaning
//   req      in   req_valid/req_ready/req_data  one image value per transaction
//   rsp      out  rsp_valid/rsp_ready/rsp_data  one cycle member per transaction
//
// Loading accepts one entry per cycle. After the last entry: a check step,
// then a scan read and compare per fixed point or cycle start, a read, emit
// and later skip in the scan per other cycle member, and a final step that
// registers the last result; a rejected run goes from the check to its result.
// req_ready is low from the last entry until the final result is registered.
// Synchronous active-high reset. An rsp stall holds the walk once the output
// register and one-deep hold are full; final and reject results wait on the register.
// ----------------------------------------------------------------------------
module permutation_cycle_decompose #(
   parameter int MAX_ELEMENTS = pce_pkg::PCE_MAX_ELEMENTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pce_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pce_pkg::rsp_type rsp_data
);
   import pce_pkg::*;

   localparam int IW   = $clog2(MAX_ELEMENTS);
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int CMPW = (CW > PCE_VALUE_W) ? CW : PCE_VALUE_W;
   localparam logic [CW-1:0]   MAX_CNT = CW'(MAX_ELEMENTS);
   localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_ELEMENTS);
   localparam int SEEN_D = 1 << PCE_VALUE_W;

   logic [CW-1:0]          count_ff, count_in;
   logic [SEEN_D-1:0]      seen_ff, seen_in;
   logic [PCE_VALUE_W-1:0] max_ff, max_in;
   logic                   bad_ff, bad_in;

   logic                   accept;
   logic                   full;
   logic                   wr_en;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic [PCE_VALUE_W-1:0] rd_data;
   run_ctrl_type           ctrl;
   walk_status_type        status;

   assign accept    = req_valid && req_ready;
   assign full      = count_ff >= MAX_CNT;
   assign wr_en     = accept && !full;
   assign req_ready = status.load_open;

   always_comb begin
      count_in = count_ff;
      seen_in  = seen_ff;
      max_in   = max_ff;
      bad_in   = bad_ff;
      if (status.clear_run) begin
         count_in = '0;
         seen_in  = '0;
         max_in   = '0;
         bad_in   = 1'b0;
      end else if (accept) begin
         if (full) begin
            bad_in = 1'b1;
         end else begin
            if ((CMPW'(req_data.image_value) >= MAX_CMP) || seen_ff[req_data.image_value]) begin
               bad_in = 1'b1;
            end
            seen_in[req_data.image_value] = 1'b1;
            count_in = CW'(count_ff + 1'b1);
            if (req_data.image_value > max_ff) begin
               max_in = req_data.image_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= '0;
         max_ff   <= '0;
         bad_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
         max_ff   <= max_in;
         bad_ff   <= bad_in;
      end
   end

   assign ctrl.last_accepted = accept && req_data.load_last;
   assign ctrl.bad           = bad_ff || (CMPW'(max_ff) >= CMPW'(count_ff));

   pce_ram #(
      .WIDTH (PCE_VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (req_data.image_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pce_walker #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .count     (count_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/pce_ram.sv @@
// ----------------------------------------------------------------------------
// pce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pce_walker.sv @@
// ----------------------------------------------------------------------------
// pce_walker
// Sequencer that scans the loaded permutation, chases each cycle through the
// image RAM and emits member indices through a one-deep hold and output reg.
// ----------------------------------------------------------------------------
module pce_walker #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pce_pkg::run_ctrl_type             ctrl,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0] count,
   output logic                              rd_en,
   output logic [$clog2(MAX_ELEMENTS)-1:0]   rd_addr,
   input  logic [pce_pkg::PCE_VALUE_W-1:0]   rd_data,
   output pce_pkg::walk_status_type          status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pce_pkg::rsp_type                  rsp_data
);
   import pce_pkg::*;

   localparam int IW   = $clog2(MAX_ELEMENTS);
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int CMPW = (CW > PCE_VALUE_W) ? CW : PCE_VALUE_W;

   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_BAD   = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_SWAIT = 7'b0010000,
      S_CHASE = 7'b0100000,
      S_CWAIT = 7'b1000000
   } state_type;

   // S_DONE is folded into S_SCAN when the scan index reaches the count.

   state_type             state_ff, state_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [MAX_ELEMENTS-1:0] visited_ff, visited_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  can_emit;
   logic [CMPW-1:0]       i_ext, cur_ext, d_ext;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_emit = !pend_valid_ff || out_free;
   assign i_ext    = CMPW'(i_ff);
   assign cur_ext  = CMPW'(cur_ff);
   assign d_ext    = CMPW'(rd_data);

   always_comb begin
      state_in         = state_ff;
      i_in             = i_ff;
      cur_in           = cur_ff;
      visited_in       = visited_ff;
      pend_valid_in    = pend_valid_ff;
      pend_in          = pend_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      rd_en            = 1'b0;
      rd_addr          = i_ff[IW-1:0];
      status.load_open = 1'b0;
      status.clear_run = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            status.load_open = 1'b1;
            if (ctrl.last_accepted) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            i_in     = '0;
            state_in = ctrl.bad ? S_BAD : S_SCAN;
         end
         S_BAD: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = '{member_index: '0, cycle_end: 1'b0, run_end: 1'b1,
                                    no_cycles: 1'b0, bad_input: 1'b1};
               status.clear_run = 1'b1;
               visited_in       = '0;
               state_in         = S_LOAD;
            end
         end
         S_SCAN: begin
            if (i_ff == count) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_data_in         = pend_ff;
                     rsp_data_in.run_end = 1'b1;
                  end else begin
                     rsp_data_in = '{member_index: '0, cycle_end: 1'b0, run_end: 1'b1,
                                     no_cycles: 1'b1, bad_input: 1'b0};
                  end
                  pend_valid_in    = 1'b0;
                  status.clear_run = 1'b1;
                  visited_in       = '0;
                  state_in         = S_LOAD;
               end
            end else if (visited_ff[i_ff[IW-1:0]]) begin
               i_in = CW'(i_ff + 1'b1);
            end else begin
               visited_in[i_ff[IW-1:0]] = 1'b1;
               rd_en    = 1'b1;
               rd_addr  = i_ff[IW-1:0];
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (d_ext == i_ext) begin
               i_in     = CW'(i_ff + 1'b1);
               state_in = S_SCAN;
            end else if (can_emit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_ff;
               end
               pend_valid_in = 1'b1;
               pend_in       = '{member_index: i_ext[PCE_VALUE_W-1:0], cycle_end: 1'b0,
                                 run_end: 1'b0, no_cycles: 1'b0, bad_input: 1'b0};
               cur_in        = d_ext[IW-1:0];
               state_in      = S_CHASE;
            end
         end
         S_CHASE: begin
            visited_in[cur_ff] = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = cur_ff;
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (can_emit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_ff;
               end
               pend_valid_in = 1'b1;
               pend_in       = '{member_index: cur_ext[PCE_VALUE_W-1:0],
                                 cycle_end: (d_ext == i_ext), run_end: 1'b0,
                                 no_cycles: 1'b0, bad_input: 1'b0};
               if (d_ext == i_ext) begin
                  i_in     = CW'(i_ff + 1'b1);
                  state_in = S_SCAN;
               end else begin
                  cur_in   = d_ext[IW-1:0];
                  state_in = S_CHASE;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         visited_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         visited_ff    <= visited_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      i_ff        <= i_in;
      cur_ff      <= cur_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/pce_checker.sv @@
// ----------------------------------------------------------------------------
// pce_checker
// Port-level assertions for the permutation cycle decomposer, bound to top.
// ----------------------------------------------------------------------------
module pce_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pce_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pce_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.bad_input && rsp_data.no_cycles))
      else $error("bad_input and no_cycles both set");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.bad_input || rsp_data.no_cycles) |->
         rsp_data.run_end && !rsp_data.cycle_end && rsp_data.member_index == '0)
      else $error("status result malformed");

   a_run_end_closes_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_end && !rsp_data.bad_input && !rsp_data.no_cycles |->
         rsp_data.cycle_end)
      else $error("run ended inside a cycle");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.load_last |=> !req_ready)
      else $error("ready during decomposition");

endmodule

bind permutation_cycle_decompose pce_checker u_pce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
